// ===== sv/pme_pkg.sv =====
package pme_pkg;
	localparam int NumCells = 256;
	localparam int MaxMeanRun = 65535;

	typedef enum logic [2:0] {
		ACT_READ = 3'd0,
		ACT_DEPOSIT = 3'd1,
		ACT_SET = 3'd2,
		ACT_DECAY = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_MEAN = 3'd5
	} action_t;

	localparam logic [1:0] REG_CELLS = 2'd0;
	localparam logic [1:0] REG_RATE = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] cell_req;
		logic signed [31:0] operand;
		logic last;
	} in_t;

	typedef struct packed {
		logic signed [31:0] cell_value;
		logic signed [39:0] total_sum;
		logic signed [31:0] peak;
		logic signed [31:0] mean;
		logic mean_valid;
		logic error;
	} out_t;

	typedef struct packed {
		logic start;
		logic signed [47:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [47:0] quotient;
	} div_rsp_t;
endpackage

// ===== sv/pme_divider.sv =====
// Restoring signed divider, one quotient bit per cycle; quotient truncates toward zero.
module pme_divider (
	input logic clk,
	input logic arst_n,
	input pme_pkg::div_req_t req,
	output pme_pkg::div_rsp_t rsp
);
	logic [5:0] count_q;
	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [47:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] den_q;
	logic [17:0] trial;
	logic [47:0] mag;

	assign mag = req.dividend[47] ? 48'(-req.dividend) : req.dividend;
	assign trial = {rem_q[16:0], quo_q[47]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				count_q <= 6'd47;
				neg_q <= req.dividend[47];
				quo_q <= mag;
				rem_q <= '0;
				den_q <= req.divisor;
			end else if (busy_q) begin
				if (!trial[17]) begin
					rem_q <= trial;
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= {rem_q[16:0], quo_q[47]};
					quo_q <= {quo_q[46:0], 1'b0};
				end
				count_q <= count_q - 6'd1;
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = {done_q, (neg_q ? 48'(-quo_q) : quo_q)};
endmodule

// ===== sv/pheromone_map_engine_top.sv =====
// Pheromone map engine: 256 signed Q16.16 levels in a single-port memory.
// The summary sweep takes one cell per cycle through a shared adder and compare;
// decay walks each cell through read, multiply and write states with a 32x18 multiplier.
// Read, deposit, set and mean do the cell access plus a summary sweep over
// the cells_in_use cells; decay walks the cells and then sweeps (with a zero
// rate it only sweeps); clear all writes all 256 cells and then sweeps. The last
// item of a mean run adds a divide when the run had no error and counted at least
// one item. Ready is low from acceptance until the result transfers.
// After reset a clearing pass writes all 256 cells to zero before the first item is taken.
module pheromone_map_engine_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pme_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pme_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_RD, ST_WR, ST_DEC_RD, ST_DEC_MUL, ST_DEC_WR,
		ST_SUM_RD, ST_SUM_ACC, ST_DIV, ST_OUT, ST_CLR
	} state_t;

	state_t state_q;
	logic [8:0] cells_q;
	logic [16:0] rate_q;
	logic signed [31:0] thresh_q;
	logic signed [31:0] mem [0:255];
	logic signed [31:0] rdata_q;
	logic [7:0] addr;
	logic mem_we;
	logic signed [31:0] wdata;
	logic [8:0] idx_q;
	logic [8:0] n;
	pme_pkg::in_t item_q;
	logic ok_q;
	logic signed [39:0] total_q;
	logic signed [31:0] peak_q;
	logic signed [47:0] acc_q;
	logic [16:0] cnt_q;
	logic bad_q;
	logic signed [31:0] cellv_q;
	logic signed [31:0] mean_q;
	logic mean_valid_q;
	logic err_q;
	logic signed [48:0] prod_q;
	logic [16:0] factor;
	logic signed [32:0] dep_sum;
	logic signed [31:0] dep_sat;
	logic signed [40:0] tot_sum;
	logic signed [31:0] scaled;
	pme_pkg::div_req_t dreq;
	pme_pkg::div_rsp_t drsp;

	pme_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign n = (cells_q == '0) ? 9'd1 : (cells_q > 9'd256 ? 9'd256 : cells_q);
	assign factor = 17'd65536 - ((rate_q > 17'd65536) ? 17'd65536 : rate_q);
	assign dep_sum = 33'(rdata_q) + 33'(item_q.operand);
	assign dep_sat = (dep_sum > 33'sd2147483647) ? 32'sh7fffffff :
		(dep_sum < -33'sd2147483648) ? 32'sh80000000 : dep_sum[31:0];
	assign tot_sum = 41'(total_q) + 41'(rdata_q);
	// Arithmetic shift floors, which matches rounding toward minus infinity.
	assign scaled = prod_q[47:16];

	always_comb begin
		addr = idx_q[7:0];
		mem_we = 1'b0;
		wdata = '0;
		case (state_q)
			ST_INIT, ST_CLR: mem_we = 1'b1;
			ST_IDLE: addr = in_data.cell_req;
			ST_RD: addr = item_q.cell_req;
			ST_WR: begin
				addr = item_q.cell_req;
				mem_we = ok_q && (item_q.action == pme_pkg::ACT_DEPOSIT ||
					item_q.action == pme_pkg::ACT_SET);
				wdata = (item_q.action == pme_pkg::ACT_SET) ? item_q.operand : dep_sat;
			end
			ST_DEC_WR: begin
				mem_we = 1'b1;
				wdata = (scaled < thresh_q) ? '0 : scaled;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q <= '0;
			cells_q <= 9'd256;
			rate_q <= '0;
			thresh_q <= 32'sd1;
			acc_q <= '0;
			cnt_q <= '0;
			bad_q <= 1'b0;
			dreq <= '0;
			total_q <= '0;
			peak_q <= '0;
			mean_q <= '0;
			mean_valid_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			dreq.start <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					pme_pkg::REG_CELLS: cells_q <= cfg_data[8:0];
					pme_pkg::REG_RATE: rate_q <= cfg_data[16:0];
					pme_pkg::REG_THRESH: thresh_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_INIT, ST_CLR: begin
					idx_q <= idx_q + 9'd1;
					if (idx_q == 9'd255) begin
						idx_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_SUM_RD;
					end
				end
				ST_IDLE: if (in_valid) begin
					item_q <= in_data;
					ok_q <= {1'b0, in_data.cell_req} < n;
					mean_q <= '0;
					mean_valid_q <= 1'b0;
					err_q <= 1'b0;
					idx_q <= '0;
					case (in_data.action)
						pme_pkg::ACT_DECAY:
							state_q <= (rate_q == '0) ? ST_SUM_RD : ST_DEC_RD;
						pme_pkg::ACT_CLEAR: state_q <= ST_CLR;
						default: state_q <= ST_RD;
					endcase
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					err_q <= !ok_q;
					state_q <= ST_SUM_RD;
					if (item_q.action == pme_pkg::ACT_MEAN) begin
						if (!ok_q || cnt_q >= 17'(pme_pkg::MaxMeanRun)) bad_q <= 1'b1;
						else begin
							acc_q <= acc_q + 48'(rdata_q);
							cnt_q <= cnt_q + 17'd1;
						end
					end
				end
				ST_DEC_RD: state_q <= ST_DEC_MUL;
				ST_DEC_MUL: begin
					prod_q <= 49'(rdata_q) * $signed({1'b0, factor});
					state_q <= ST_DEC_WR;
				end
				ST_DEC_WR: begin
					idx_q <= idx_q + 9'd1;
					state_q <= ST_DEC_RD;
					if (idx_q + 9'd1 == n) begin
						idx_q <= '0;
						state_q <= ST_SUM_RD;
					end
				end
				ST_SUM_RD: begin
					total_q <= '0;
					state_q <= ST_SUM_ACC;
					idx_q <= idx_q + 9'd1;
				end
				ST_SUM_ACC: begin
					// rdata_q holds cell idx_q-1 here.
					if (tot_sum > 41'sd549755813887) total_q <= 40'sh7fffffffff;
					else if (tot_sum < -41'sd549755813888) total_q <= 40'sh8000000000;
					else total_q <= tot_sum[39:0];
					if (idx_q == 9'd1 || rdata_q > peak_q) peak_q <= rdata_q;
					if (ok_q && idx_q[7:0] == item_q.cell_req + 8'd1) cellv_q <= rdata_q;
					if (ok_q && item_q.cell_req == 8'd255 && idx_q == 9'd256)
						cellv_q <= rdata_q;
					idx_q <= idx_q + 9'd1;
					if (idx_q == n) begin
						idx_q <= '0;
						if (item_q.action == pme_pkg::ACT_MEAN && item_q.last) begin
							acc_q <= '0;
							cnt_q <= '0;
							bad_q <= 1'b0;
							if (!bad_q && cnt_q != '0) begin
								dreq.start <= 1'b1;
								dreq.dividend <= acc_q;
								dreq.divisor <= cnt_q;
								state_q <= ST_DIV;
							end else begin
								mean_valid_q <= !bad_q;
								state_q <= ST_OUT;
							end
						end else state_q <= ST_OUT;
					end
				end
				ST_DIV: if (drsp.done) begin
					mean_valid_q <= 1'b1;
					mean_q <= (drsp.quotient > 48'sd2147483647) ? 32'sh7fffffff :
						(drsp.quotient < -48'sd2147483648) ? 32'sh80000000 :
						drsp.quotient[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_data = {(ok_q ? cellv_q : 32'sd0), total_q, peak_q, mean_q,
		mean_valid_q, err_q};

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accepting while result pending");
	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.mean_valid) |-> out_data.mean == '0)
		else $error("mean nonzero without mean_valid");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 17'(pme_pkg::MaxMeanRun)) else $error("mean count overflow");
endmodule
